FILE: hdl/clbns_pkg.sv
// shared types, constants and helpers for the lcd bus number sniffer
package clbns_pkg;

	// number format
	localparam int FRACTION_DIGITS_DEF = 3;
	localparam int FRACTION_DIGITS_MAX = 6;
	localparam int FRAC_CNT_W          = 3;   // holds 0..FRACTION_DIGITS_MAX
	localparam int ACC_W               = 32;

	// configuration register map
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_START_CMD = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_END_CMD   = 1'b1;

	localparam logic [7:0] START_CMD_RST = 8'd128;
	localparam logic [7:0] END_CMD_RST   = 8'd192;

	// characters of interest
	localparam logic [7:0] CHAR_POINT = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// bus decoder phase
	typedef enum logic [3:0] {
		PH_START_HI = 4'b0001,
		PH_START_LO = 4'b0010,
		PH_TEXT_HI  = 4'b0100,
		PH_TEXT_LO  = 4'b1000
	} phase_t;

	// parse state handed to the scaling logic
	typedef struct packed {
		logic [ACC_W-1:0]      acc;
		logic                  in_frac;
		logic [FRAC_CNT_W-1:0] frac_cnt;
		logic                  ovf;
	} parse_t;

	// 10 to the power n, n up to FRACTION_DIGITS_MAX
	function automatic logic [31:0] pow10(input logic [FRAC_CNT_W-1:0] n);
		logic [31:0] r;
		r = 32'd1;
		for (int i = 0; i < FRACTION_DIGITS_MAX; i++) begin
			if (FRAC_CNT_W'(i) < n) begin
				r = 32'(r * 32'd10);
			end
		end
		return r;
	endfunction

endpackage

FILE: hdl/char_lcd_bus_number_sniffer_top.sv
// top level of the character lcd bus number sniffer
//
// watches the 4-bit data bus of a character lcd, one request per nibble
// sampled while the enable strobe is high; nibbles pair up high then low.
// the start command byte arms a frame, every later byte is a text character
// until the end command byte closes it. digits accumulate, '.' switches to
// fraction digits (extra ones truncated), anything else is ignored. at frame
// end one result request carries the value scaled by 10^FRACTION_DIGITS,
// clamped at all ones with a saturated flag, plus whether a point was seen.
// rate: one nibble per clock cycle sustained. a nibble is registered on
// acceptance and updates the parse state at the next edge, later only for
// a held end nibble; a frame end is scaled from the parse state and lands
// in the result register at the same edge that updates the parse state.
// only an end byte that meets a full, stalled result register
// holds up the input; all other nibbles keep flowing regardless of the
// output side. configuration writes take effect at the next edge and are
// meant to be done while the block is idle
module char_lcd_bus_number_sniffer_top #(
	parameter int FRACTION_DIGITS = clbns_pkg::FRACTION_DIGITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write port
	input  logic                            cfg_we,
	input  logic [clbns_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data,
	// nibble input
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [3:0] nibble, rest zero
	// result output
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [39:0]                     m_axis_tdata   // [31:0] value_milli,
	                                                       // [32] saturated,
	                                                       // [33] fraction_seen
);
	import clbns_pkg::*;

	// configuration registers
	logic [7:0]       start_cmd_q;
	logic [7:0]       end_cmd_q;

	// input stage
	logic             valid_s1;
	logic [3:0]       nibble_s1;

	// result stage
	logic             valid_s2;
	logic [ACC_W-1:0] value_s2;
	logic             sat_s2;
	logic             frac_s2;

	logic             step;
	logic             end_hit;
	parse_t           parse;
	logic [ACC_W-1:0] scaled;
	logic             scaled_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_cmd_q <= START_CMD_RST;
			end_cmd_q   <= END_CMD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_CMD: start_cmd_q <= cfg_data;
				REG_END_CMD:   end_cmd_q   <= cfg_data;
				default:       ;
			endcase
		end
	end

	// the registered nibble is consumed unless it closes a frame and the
	// result register is occupied and not being read
	assign step          = valid_s1 && (!end_hit || !valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			nibble_s1 <= s_axis_tdata[3:0];
		end
	end

	// byte assembly and parse state
	clbns_parser #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.nibble   (nibble_s1),
		.start_cmd(start_cmd_q),
		.end_cmd  (end_cmd_q),
		.end_hit  (end_hit),
		.parse    (parse)
	);

	// scaling of the settled parse state, used only on an end byte
	clbns_scale #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_scale (
		.parse(parse),
		.value(scaled),
		.sat  (scaled_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step && end_hit) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && end_hit) begin
			value_s2 <= scaled;
			sat_s2   <= scaled_sat;
			frac_s2  <= parse.in_frac;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'd0, frac_s2, sat_s2, value_s2};

endmodule

FILE: hdl/clbns_parser.sv
// lcd bus byte assembly, frame detection and decimal parse state
module clbns_parser #(
	parameter int FRACTION_DIGITS = clbns_pkg::FRACTION_DIGITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [3:0]           nibble,
	input  logic [7:0]           start_cmd,
	input  logic [7:0]           end_cmd,
	output logic                 end_hit,
	output clbns_pkg::parse_t    parse
);
	import clbns_pkg::*;

	phase_t                phase_q, phase_d;
	logic [3:0]            high_q, high_d;
	parse_t                parse_q, parse_d;
	logic [7:0]            byte_w;
	logic [3:0]            digit;
	logic [ACC_W+3:0]      next_acc;
	logic                  is_digit;

	assign byte_w   = {high_q, nibble};
	assign end_hit  = (phase_q == PH_TEXT_LO) && (byte_w == end_cmd);
	assign digit    = 4'(byte_w - CHAR_ZERO);
	assign is_digit = (byte_w >= CHAR_ZERO) && (byte_w <= CHAR_NINE);
	// acc * 10 + digit as (acc << 3) + (acc << 1) + digit
	assign next_acc = ({4'd0, parse_q.acc} << 3) + ({4'd0, parse_q.acc} << 1)
		+ {(ACC_W)'(0), digit};

	always_comb begin
		phase_d = phase_q;
		high_d  = high_q;
		parse_d = parse_q;
		unique case (phase_q)
			PH_START_HI: begin
				if (nibble == start_cmd[7:4]) begin
					high_d  = nibble;
					phase_d = PH_START_LO;
				end
			end
			PH_START_LO: begin
				if (byte_w == start_cmd) begin
					parse_d = '0;
					phase_d = PH_TEXT_HI;
				end else begin
					phase_d = PH_START_HI;
				end
			end
			PH_TEXT_HI: begin
				high_d  = nibble;
				phase_d = PH_TEXT_LO;
			end
			PH_TEXT_LO: begin
				if (end_hit) begin
					parse_d = '0;
					phase_d = PH_START_HI;
				end else begin
					phase_d = PH_TEXT_HI;
					if (byte_w == CHAR_POINT) begin
						parse_d.in_frac = 1'b1;
					end else if (is_digit &&
						!(parse_q.in_frac &&
						  parse_q.frac_cnt >= FRAC_CNT_W'(FRACTION_DIGITS))) begin
						if (parse_q.in_frac) begin
							parse_d.frac_cnt = parse_q.frac_cnt + 1'b1;
						end
						// once clamped, later digits leave the value alone
						if (!parse_q.ovf) begin
							if (|next_acc[ACC_W+3:ACC_W]) begin
								parse_d.acc = '1;
								parse_d.ovf = 1'b1;
							end else begin
								parse_d.acc = next_acc[ACC_W-1:0];
							end
						end
					end
				end
			end
			default: begin
				phase_d = PH_START_HI;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START_HI;
			high_q  <= '0;
			parse_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			high_q  <= high_d;
			parse_q <= parse_d;
		end
	end

	assign parse = parse_q;

endmodule

FILE: hdl/clbns_scale.sv
// frame end scaling to fixed point with saturation
module clbns_scale #(
	parameter int FRACTION_DIGITS = clbns_pkg::FRACTION_DIGITS_DEF
) (
	input  clbns_pkg::parse_t        parse,
	output logic [clbns_pkg::ACC_W-1:0] value,
	output logic                     sat
);
	import clbns_pkg::*;

	localparam int ScaleW = $clog2(10 ** FRACTION_DIGITS + 1);

	logic [FRAC_CNT_W-1:0]    missing;
	logic [ScaleW-1:0]        factor;
	logic [ACC_W+ScaleW-1:0]  product;

	// fraction digits still owed, each one a factor of ten
	assign missing = FRAC_CNT_W'(FRACTION_DIGITS) - parse.frac_cnt;
	assign factor  = ScaleW'(pow10(missing));
	assign product = (ACC_W+ScaleW)'(parse.acc) * (ACC_W+ScaleW)'(factor);
	assign sat     = parse.ovf || (|product[ACC_W+ScaleW-1:ACC_W]);
	assign value   = sat ? '1 : product[ACC_W-1:0];

endmodule

FILE: test/tb_char_lcd_bus_number_sniffer_top.sv
// testbench for the character lcd bus number sniffer: directed and random frames with a checker
`timescale 1ns / 100ps

module tb_char_lcd_bus_number_sniffer_top;

	import clbns_pkg::*;

	localparam int          FRAC_DIGITS    = FRACTION_DIGITS_DEF;
	localparam logic [63:0] ACC_MAX        = 64'hFFFF_FFFF;
	localparam int          IDLE_TAIL      = 8;     // margin for in-flight nibbles to settle
	localparam int          STALL_CYCLES   = 300;   // long receiver hold-off
	localparam int          RANDOM_NIBBLES = 700;

	// one decoded reading as it leaves the block
	typedef struct {
		logic [31:0] value_milli;
		logic        saturated;
		logic        fraction_seen;
	} lcd_reading_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [7:0]             cfg_data;

	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [3:0] nibble, [7:4] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // [31:0] value_milli, [32] saturated, [33] fraction_seen

	// bus decoder copy: commands and parse state
	logic [7:0]  cmd_start;
	logic [7:0]  cmd_end;
	phase_t      dec_phase;
	logic [3:0]  dec_hi;
	logic [31:0] dec_acc;
	logic        dec_in_frac;
	int          dec_frac_cnt;
	logic        dec_ovf;

	lcd_reading_t readings_due[$];
	logic [7:0]   frame_body[$];

	int unsigned nibbles_sent = 0;
	int unsigned mismatches   = 0;
	bit          tx_gapless   = 1'b0;
	bit          rx_gapless   = 1'b0;
	int          rx_hold_len  = 0;

	char_lcd_bus_number_sniffer_top #(
		.FRACTION_DIGITS(FRAC_DIGITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void clear_parse();
		dec_acc      = '0;
		dec_in_frac  = 1'b0;
		dec_frac_cnt = 0;
		dec_ovf      = 1'b0;
	endfunction

	// advance the decoder copy by one accepted nibble, queue a reading on frame end
	task automatic decode_nibble(input logic [3:0] nib);
		logic [7:0]   b;
		logic [63:0]  nxt;
		logic [63:0]  v;
		logic         sat;
		lcd_reading_t r;
		b = {dec_hi, nib};
		case (dec_phase)
			PH_START_HI: begin
				// hunting: only the start command's high nibble gets us going
				if (nib == cmd_start[7:4]) begin
					dec_hi    = nib;
					dec_phase = PH_START_LO;
				end
			end
			PH_START_LO: begin
				if (b == cmd_start) begin
					clear_parse();
					dec_phase = PH_TEXT_HI;
				end else begin
					dec_phase = PH_START_HI;
				end
			end
			PH_TEXT_HI: begin
				dec_hi    = nib;
				dec_phase = PH_TEXT_LO;
			end
			default: begin
				if (b != cmd_end) begin
					dec_phase = PH_TEXT_HI;
					if (b == CHAR_POINT) begin
						dec_in_frac = 1'b1;
					end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
						// fraction digits past the kept count are dropped
						if (!(dec_in_frac && dec_frac_cnt >= FRAC_DIGITS)) begin
							if (dec_in_frac) begin
								dec_frac_cnt++;
							end
							if (!dec_ovf) begin
								nxt = {32'd0, dec_acc} * 64'd10 + {56'd0, b - CHAR_ZERO};
								if (nxt > ACC_MAX) begin
									dec_acc = '1;
									dec_ovf = 1'b1;
								end else begin
									dec_acc = nxt[31:0];
								end
							end
						end
					end
				end else begin
					// frame end: scale by the missing fraction digits, clamp on overflow
					v   = {32'd0, dec_acc};
					sat = dec_ovf;
					for (int k = dec_frac_cnt; k < FRAC_DIGITS; k++) begin
						v = v * 64'd10;
						if (v > ACC_MAX) begin
							v   = ACC_MAX;
							sat = 1'b1;
						end
					end
					if (sat) begin
						v = ACC_MAX;
					end
					r.value_milli   = v[31:0];
					r.saturated     = sat;
					r.fraction_seen = dec_in_frac;
					readings_due.push_back(r);
					clear_parse();
					dec_phase = PH_START_HI;
				end
			end
		endcase
	endtask

	// offer one nibble request after a random gap, return at the accepting edge
	task automatic send_nibble(input logic [3:0] nib);
		int gap;
		gap = tx_gapless ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'h0, nib};
		do @(posedge clk); while (!s_axis_tready);
		nibbles_sent++;
		decode_nibble(nib);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_nibble(b[7:4]);
		send_nibble(b[3:0]);
	endtask

	// start command, the queued text bytes, end command
	task automatic send_frame();
		send_byte(cmd_start);
		foreach (frame_body[i]) begin
			send_byte(frame_body[i]);
		end
		send_byte(cmd_end);
	endtask

	task automatic send_text(input string text);
		frame_body.delete();
		for (int i = 0; i < text.len(); i++) begin
			frame_body.push_back(text[i]);
		end
		send_frame();
	endtask

	// drain: every reading back, then let any result-free nibbles settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (readings_due.size() != 0) @(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	// only called while idle; the extra edge keeps back-to-back writes apart
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_START_CMD) begin
			cmd_start = val;
		end else begin
			cmd_end = val;
		end
		@(posedge clk);
	endtask

	task automatic check_reading(input logic [39:0] data);
		lcd_reading_t want;
		if (readings_due.size() == 0) begin
			$display("%0t: reading with none expected, actual value_milli %0d sat %0b frac %0b",
				$time, data[31:0], data[32], data[33]);
			mismatches++;
		end else begin
			want = readings_due.pop_front();
			if (data[31:0] !== want.value_milli) begin
				$display("%0t: value_milli expected %0d actual %0d",
					$time, want.value_milli, data[31:0]);
				mismatches++;
			end
			if (data[32] !== want.saturated) begin
				$display("%0t: saturated expected %0b actual %0b", $time, want.saturated, data[32]);
				mismatches++;
			end
			if (data[33] !== want.fraction_seen) begin
				$display("%0t: fraction_seen expected %0b actual %0b",
					$time, want.fraction_seen, data[33]);
				mismatches++;
			end
		end
	endtask

	function automatic logic [7:0] random_char();
		int unsigned p;
		p = $urandom_range(0, 9);
		if (p < 7) begin
			return CHAR_ZERO + 8'($urandom_range(0, 9));
		end else if (p == 7) begin
			return CHAR_POINT;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] random_command();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return START_CMD_RST;
			3:       return END_CMD_RST;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_basic_frames();
		send_text("");          // empty frame reads zero, no flags
		send_text("7");
		send_text("12.5");
		send_text("0.0625");    // fourth fraction digit truncated
		send_text("1..2");      // repeated points
		send_text("x9y");       // non-digits ignored
		wait_idle();
	endtask

	task automatic test_saturation();
		send_text("4294967");      // largest integer that scales without clamp
		send_text("4294968");      // clamp during scaling
		send_text("4294967.295");  // all ones exactly, not saturated
		send_text("4294967296");   // accumulator overflow on the last digit
		send_text("99999999999");  // later digits after overflow leave it clamped
		wait_idle();
	endtask

	task automatic test_start_hunting();
		send_nibble(cmd_start[7:4]);   // right high nibble, wrong low nibble
		send_nibble(~cmd_start[3:0]);
		send_nibble(4'h3);             // dropped while hunting
		frame_body.delete();
		frame_body.push_back(CHAR_ZERO + 8'd5);
		frame_body.push_back(cmd_start);   // start byte inside text is just a char
		frame_body.push_back(8'h61);
		frame_body.push_back(8'hFF);
		frame_body.push_back(8'h00);
		frame_body.push_back(CHAR_POINT);
		frame_body.push_back(CHAR_ZERO + 8'd2);
		send_frame();
		wait_idle();
	endtask

	task automatic test_command_extremes();
		write_reg(REG_START_CMD, 8'h00);
		write_reg(REG_END_CMD, 8'hFF);
		send_text("8.1");
		wait_idle();
		write_reg(REG_START_CMD, 8'hFF);
		write_reg(REG_END_CMD, 8'h00);
		send_text("0");
		wait_idle();
		// same byte for both commands, and it is a digit
		write_reg(REG_START_CMD, CHAR_ZERO + 8'd5);
		write_reg(REG_END_CMD, CHAR_ZERO + 8'd5);
		send_text("12");
		wait_idle();
		write_reg(REG_START_CMD, START_CMD_RST);
		write_reg(REG_END_CMD, END_CMD_RST);
	endtask

	// receiver holds off while frames stream in back to back, so the input stalls
	task automatic test_output_stall();
		tx_gapless  = 1'b1;
		rx_hold_len = STALL_CYCLES;
		repeat (12) send_text("65.536");
		tx_gapless = 1'b0;
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int unsigned goal;
		int unsigned next_cfg;
		int unsigned pick;
		int unsigned len;
		goal     = nibbles_sent + RANDOM_NIBBLES;
		next_cfg = nibbles_sent;
		while (nibbles_sent < goal) begin
			if (nibbles_sent >= next_cfg) begin
				wait_idle();
				write_reg(REG_START_CMD, random_command());
				write_reg(REG_END_CMD, random_command());
				tx_gapless = ($urandom_range(0, 3) == 0);
				rx_gapless = ($urandom_range(0, 3) == 0);
				next_cfg   = nibbles_sent + $urandom_range(80, 200);
			end
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				// well-formed frame, now and then long enough to overflow
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
				frame_body.delete();
				repeat (len) frame_body.push_back(random_char());
				send_frame();
			end else if (pick < 95) begin
				// noise: loose nibbles while hunting, whole bytes inside text
				if (dec_phase == PH_TEXT_HI) begin
					repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
				end else begin
					repeat ($urandom_range(1, 6)) send_nibble(4'($urandom_range(0, 15)));
				end
			end else begin
				// broken frame: no end command, the next start byte lands in the text
				send_byte(cmd_start);
				repeat ($urandom_range(0, 4)) send_byte(random_char());
			end
		end
		tx_gapless = 1'b0;
		rx_gapless = 1'b0;
	endtask

	// ---------------------------------------------------------------- processes

	// result side: random tready gaps, a long hold when asked, check every request
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_len > 0) begin
				gap         = rx_hold_len;
				rx_hold_len = 0;
			end else begin
				gap = rx_gapless ? 0 : $urandom_range(0, 11);
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid && rx_hold_len == 0) @(posedge clk);
			if (m_axis_tvalid) begin
				check_reading(m_axis_tdata);
			end
		end
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_START_CMD;
		cfg_data      <= 8'h00;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'h00;
		m_axis_tready <= 1'b0;
		cmd_start = START_CMD_RST;
		cmd_end   = END_CMD_RST;
		dec_phase = PH_START_HI;
		dec_hi    = 4'h0;
		clear_parse();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_frames();
		test_saturation();
		test_start_hunting();
		test_command_extremes();
		test_output_stall();
		test_random_traffic();
		wait_idle();

		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: char_lcd_bus_number_sniffer_top.f
hdl/clbns_pkg.sv
hdl/clbns_parser.sv
hdl/clbns_scale.sv
hdl/char_lcd_bus_number_sniffer_top.sv
test/tb_char_lcd_bus_number_sniffer_top.sv
